@@ design/bba_pkg.sv @@
package bba_pkg;

  // defaults for the top level parameters
  localparam int DEF_BITS_PER_MAP_BLOCK = 4096;
  localparam int DEF_MAX_MAP_BLOCKS     = 4;

  // map storage word
  localparam int WORD_BITS = 64;
  localparam int WORD_LSB  = 6;

  // field and register widths
  localparam int BLK_W    = 16;
  localparam int STAT_W   = 2;
  localparam int INODE_W  = 10;
  localparam int MAPB_W   = 3;
  localparam int USABLE_W = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 15;
  localparam int BASE_W   = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INODE_BLOCKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_BLOCKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USABLE_COUNT = 2'd2;

  // reset values of the registers
  localparam logic [INODE_W-1:0]  RST_INODE_BLOCKS = 10'd1;
  localparam logic [MAPB_W-1:0]   RST_MAP_BLOCKS   = 3'd1;
  localparam logic [USABLE_W-1:0] RST_USABLE_COUNT = 15'd4096;

  // commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BELOW  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BEYOND = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic start;
    logic scan_en;
    logic free_chk;
    logic free_rd;
    logic free_wr;
    logic load_out;
  } bba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic free_err;
  } bba_sts_t;

endpackage

@@ design/bba_ctrl.sv @@
module bba_ctrl import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_command,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  input  bba_sts_t sts,
  output bba_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FCHK  = 3'd3;
  localparam logic [2:0] S_FRD   = 3'd4;
  localparam logic [2:0] S_FWR   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       can_load;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign can_load  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.clr_en   = (state_r == S_CLEAR);
    cmd.start    = accept;
    cmd.scan_en  = (state_r == S_SCAN);
    cmd.free_chk = (state_r == S_FCHK);
    cmd.free_rd  = (state_r == S_FRD);
    cmd.free_wr  = (state_r == S_FWR);
    cmd.load_out = (state_r == S_DONE) && can_load;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = (in_command == CMD_FREE) ? S_FCHK : S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_DONE;
      end
      S_FCHK: begin
        state_nxt = sts.free_err ? S_DONE : S_FRD;
      end
      S_FRD:  state_nxt = S_FWR;
      S_FWR:  state_nxt = S_DONE;
      S_DONE: begin
        if (can_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ design/bba_dpath.sv @@
module bba_dpath import bba_pkg::*; #(
  parameter int BITS_PER_MAP_BLOCK = DEF_BITS_PER_MAP_BLOCK,
  parameter int MAX_MAP_BLOCKS     = DEF_MAX_MAP_BLOCKS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic [BLK_W-1:0]     in_block_number,
  input  bba_cmd_t             cmd,
  output bba_sts_t             sts,
  output logic [BLK_W-1:0]     out_granted_block,
  output logic [STAT_W-1:0]    out_status
);

  localparam int MAP_BITS  = MAX_MAP_BLOCKS * BITS_PER_MAP_BLOCK;
  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IW        = $clog2(MAP_WORDS + 2);
  localparam int W         = (IW + WORD_LSB > BLK_W) ? IW + WORD_LSB : BLK_W;
  localparam int EW_RAW    = $clog2(MAX_MAP_BLOCKS + 1);
  localparam int EW        = (EW_RAW > MAPB_W) ? EW_RAW : MAPB_W;

  // configuration registers
  logic [INODE_W-1:0]  inode_blocks_r;
  logic [MAPB_W-1:0]   map_blocks_r;
  logic [USABLE_W-1:0] usable_count_r;

  // per transaction
  logic [BLK_W-1:0]    blk_r;
  logic [BASE_W-1:0]   base_r;
  logic [W-1:0]        span_r;
  logic [W-1:0]        limit_r;
  logic [W-1:0]        off_r;
  logic [IW-1:0]       issue_w_r;
  logic [IW-1:0]       chk_w_r;
  logic                chk_vld_r;
  logic [AW-1:0]       clr_cnt_r;
  logic [BLK_W-1:0]    res_granted_r;
  logic [STAT_W-1:0]   res_status_r;
  logic [BLK_W-1:0]    out_granted_r;
  logic [STAT_W-1:0]   out_status_r;

  // map storage
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [EW-1:0]        eff_mb;
  logic [W-1:0]         span_nxt;
  logic [W-1:0]         limit_nxt;
  logic [BASE_W-1:0]    base_nxt;

  logic [W-1:0]         word_base;
  logic                 past_limit;
  logic [W-1:0]         remain;
  logic [WORD_BITS-1:0] lim_mask;
  logic [WORD_BITS-1:0] avail;
  logic [WORD_LSB-1:0]  pos;
  logic                 found;
  logic                 hit;
  logic [WORD_BITS-1:0] hit_bit;
  logic [W-1:0]         grant_full;

  logic                 below;
  logic [W-1:0]         off_c;
  logic                 beyond;
  logic [AW-1:0]        off_word;
  logic [AW-1:0]        scan_addr;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inode_blocks_r <= RST_INODE_BLOCKS;
      map_blocks_r   <= RST_MAP_BLOCKS;
      usable_count_r <= RST_USABLE_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INODE_BLOCKS: inode_blocks_r <= cfg_data[INODE_W-1:0];
        REG_MAP_BLOCKS:   map_blocks_r   <= cfg_data[MAPB_W-1:0];
        REG_USABLE_COUNT: usable_count_r <= cfg_data[USABLE_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry, latched when a transaction starts
  always_comb begin
    base_nxt = BASE_W'(1) + BASE_W'(inode_blocks_r) + BASE_W'(map_blocks_r);
    if (EW'(map_blocks_r) > EW'(MAX_MAP_BLOCKS)) eff_mb = EW'(MAX_MAP_BLOCKS);
    else eff_mb = EW'(map_blocks_r);
    span_nxt  = W'(eff_mb) * W'(BITS_PER_MAP_BLOCK);
    limit_nxt = (span_nxt > W'(usable_count_r)) ? W'(usable_count_r) : span_nxt;
  end

  // scan of the word in rd_data_r
  always_comb begin
    word_base  = W'({chk_w_r, {WORD_LSB{1'b0}}});
    past_limit = (word_base >= limit_r);
    remain     = limit_r - word_base;
    if (remain >= W'(WORD_BITS)) lim_mask = '1;
    else lim_mask = (WORD_BITS'(1) << remain[WORD_LSB-1:0]) - WORD_BITS'(1);
    avail = ~rd_data_r & lim_mask;
    pos   = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) pos = WORD_LSB'(j);
    end
    found      = |avail;
    hit        = cmd.scan_en && chk_vld_r && !past_limit && found;
    hit_bit    = WORD_BITS'(1) << pos;
    grant_full = W'(base_r) + W'({chk_w_r, pos});
  end

  // range check for a free
  always_comb begin
    below    = (W'(blk_r) < W'(base_r));
    off_c    = W'(blk_r) - W'(base_r);
    beyond   = (off_c >= span_r);
    off_word = off_r[AW+WORD_LSB-1:WORD_LSB];
  end

  assign scan_addr = (issue_w_r < IW'(MAP_WORDS)) ? issue_w_r[AW-1:0] : '0;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_r;
    mem_wdata = '0;
    if (cmd.clr_en) begin
      mem_we = 1'b1;
    end else if (hit) begin
      mem_we    = 1'b1;
      mem_waddr = chk_w_r[AW-1:0];
      mem_wdata = rd_data_r | hit_bit;
    end else if (cmd.free_wr) begin
      mem_we    = 1'b1;
      mem_waddr = off_word;
      mem_wdata = rd_data_r & ~(WORD_BITS'(1) << off_r[WORD_LSB-1:0]);
    end
    mem_raddr = cmd.free_rd ? off_word : scan_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= map_mem[mem_raddr];
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr_en) clr_cnt_r <= clr_cnt_r + AW'(1);
  end

  assign sts.clr_last  = (clr_cnt_r == AW'(MAP_WORDS - 1));
  assign sts.scan_done = cmd.scan_en && chk_vld_r && (past_limit || found);
  assign sts.free_err  = below || beyond;

  // scan pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
    end else if (cmd.start) begin
      chk_vld_r <= 1'b0;
    end else if (cmd.scan_en) begin
      chk_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      blk_r     <= in_block_number;
      base_r    <= base_nxt;
      span_r    <= span_nxt;
      limit_r   <= limit_nxt;
      issue_w_r <= '0;
      chk_w_r   <= '0;
    end else if (cmd.scan_en) begin
      issue_w_r <= issue_w_r + IW'(1);
      chk_w_r   <= issue_w_r;
    end
    if (cmd.free_chk) off_r <= off_c;
  end

  // result and output registers
  always_ff @(posedge clk) begin
    if (sts.scan_done) begin
      if (past_limit) begin
        res_granted_r <= '0;
        res_status_r  <= ST_FULL;
      end else begin
        res_granted_r <= grant_full[BLK_W-1:0];
        res_status_r  <= ST_OK;
      end
    end else if (cmd.free_chk) begin
      res_granted_r <= '0;
      if (below) res_status_r <= ST_BELOW;
      else if (beyond) res_status_r <= ST_BEYOND;
      else res_status_r <= ST_OK;
    end
    if (cmd.load_out) begin
      out_granted_r <= res_granted_r;
      out_status_r  <= res_status_r;
    end
  end

  assign out_granted_block = out_granted_r;
  assign out_status        = out_status_r;

endmodule

@@ design/bitmap_block_allocator.sv @@
// First-fit bitmap block allocator. One map bit per data block lives in a
// single-port-write, registered-read memory of 64-bit words. After reset the
// block clears the map one word a cycle (MAX_MAP_BLOCKS * BITS_PER_MAP_BLOCK / 64
// words, 256 at the defaults) with in_ready low; configuration writes are
// taken at any time. An allocate reads the map one word per cycle and stops at
// the first word holding a free bit below the scan limit, or at the scan limit
// with status full. A free checks the number, then reads and rewrites its map
// word; a rejected number skips the read and the write. One transaction is
// worked on at a time; a finished result sits in the output register while the
// next one is accepted.
module bitmap_block_allocator import bba_pkg::*; #(
  parameter int BITS_PER_MAP_BLOCK = DEF_BITS_PER_MAP_BLOCK,
  parameter int MAX_MAP_BLOCKS     = DEF_MAX_MAP_BLOCKS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_command,
  input  logic [BLK_W-1:0]     in_block_number,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BLK_W-1:0]     out_granted_block,
  output logic [STAT_W-1:0]    out_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  bba_cmd_t cmd;
  bba_sts_t sts;

  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .sts        (sts),
    .cmd        (cmd)
  );

  bba_dpath #(
    .BITS_PER_MAP_BLOCK (BITS_PER_MAP_BLOCK),
    .MAX_MAP_BLOCKS     (MAX_MAP_BLOCKS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_block_number   (in_block_number),
    .cmd               (cmd),
    .sts               (sts),
    .out_granted_block (out_granted_block),
    .out_status        (out_status)
  );

endmodule

@@ test/tb_bitmap_block_allocator.sv @@
`timescale 1ns / 100ps

module tb_bitmap_block_allocator;
  import bba_pkg::*;

  localparam int BPB      = DEF_BITS_PER_MAP_BLOCK;
  localparam int MAX_MB   = DEF_MAX_MAP_BLOCKS;
  localparam int MAP_BITS = BPB * MAX_MB;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // decoded to nothing
  localparam int HOLD_AT  = 250;
  localparam int HOLD_LEN = 300;
  localparam int PHASES   = 7;
  localparam int PHASE_OPS = 90;

  typedef struct packed {
    logic [BLK_W-1:0]  blk;
    logic [STAT_W-1:0] st;
  } grant_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
    logic                 cmd;
    logic [BLK_W-1:0]     blk;
    logic                 fixed;
    grant_t               want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_command;
  logic [BLK_W-1:0]     in_block_number;
  logic                 out_valid;
  logic                 out_ready;
  logic [BLK_W-1:0]     out_granted_block;
  logic [STAT_W-1:0]    out_status;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  bitmap_block_allocator u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_block_number   (in_block_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_granted_block (out_granted_block),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the allocator: taken bits and registers
  bit [MAP_BITS-1:0]    taken_map;
  logic [INODE_W-1:0]   inode_r;
  logic [MAPB_W-1:0]    mapb_r;
  logic [USABLE_W-1:0]  usable_r;

  grant_t    grants_due[$];
  plan_row_t plan[$];
  int        n_sent;
  int        n_got;
  int        n_bad;

  function automatic int unsigned data_base();
    return 1 + inode_r + mapb_r;
  endfunction

  function automatic int unsigned scan_limit();
    int unsigned lim;
    lim = (mapb_r > MAX_MB ? MAX_MB : mapb_r) * BPB;
    if (lim > usable_r) lim = usable_r;
    if (lim > MAP_BITS) lim = MAP_BITS;
    return lim;
  endfunction

  function automatic grant_t apply_block_op(input logic cmd, input logic [BLK_W-1:0] blk);
    int unsigned base;
    int unsigned lim;
    int unsigned off;
    int unsigned i;
    grant_t g;
    base = data_base();
    g.blk = '0;
    g.st = ST_OK;
    if (cmd == CMD_ALLOC) begin
      lim = scan_limit();
      g.st = ST_FULL;
      for (i = 0; i < lim && g.st == ST_FULL; i++) begin
        if (!taken_map[i]) begin
          taken_map[i] = 1'b1;
          g.blk = BLK_W'(base + i);  // low bits only
          g.st = ST_OK;
        end
      end
    end else if (blk < base) begin
      g.st = ST_BELOW;
    end else begin
      off = blk - base;
      if (off / BPB >= mapb_r || off / BPB >= MAX_MB || off >= MAP_BITS) begin
        g.st = ST_BEYOND;
      end else begin
        taken_map[off] = 1'b0;
      end
    end
    return g;
  endfunction

  task automatic plan_op(input logic cmd, input int blk);
    plan_row_t r;
    r = '0;
    r.cmd = cmd;
    r.blk = BLK_W'(blk);
    plan.push_back(r);
  endtask

  task automatic plan_check(input logic cmd, input int blk, input int gblk,
                            input logic [STAT_W-1:0] st);
    plan_row_t r;
    r = '0;
    r.cmd = cmd;
    r.blk = BLK_W'(blk);
    r.fixed = 1'b1;
    r.want.blk = BLK_W'(gblk);
    r.want.st = st;
    plan.push_back(r);
  endtask

  task automatic plan_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = CFG_DAT_W'(data);
    plan.push_back(r);
  endtask

  task automatic send_item(input logic cmd, input logic [BLK_W-1:0] blk,
                           input logic fixed, input grant_t want);
    int unsigned gap;
    grant_t g;
    gap = ((n_sent % 100) >= 80) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_block_number <= blk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    g = apply_block_op(cmd, blk);
    grants_due.push_back(fixed ? want : g);
    n_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_INODE_BLOCKS: inode_r = data[INODE_W-1:0];
      REG_MAP_BLOCKS:   mapb_r = data[MAPB_W-1:0];
      REG_USABLE_COUNT: usable_r = data[USABLE_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // every command gives one result, so an empty queue means the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    plan_row_t   row;
    grant_t      none;
    int unsigned base;
    int unsigned lim;
    int unsigned span;
    int unsigned r;
    int unsigned ib;
    int unsigned mb;
    int unsigned uc;
    logic [BLK_W-1:0] blk;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_ALLOC;
    in_block_number = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_INODE_BLOCKS;
    cfg_data = '0;
    taken_map = '0;
    inode_r = RST_INODE_BLOCKS;
    mapb_r = RST_MAP_BLOCKS;
    usable_r = RST_USABLE_COUNT;
    none = '0;
    n_sent = 0;
    n_got = 0;
    n_bad = 0;

    // reset values: base 3
    plan_check(CMD_ALLOC, 0, 3, ST_OK);
    plan_check(CMD_ALLOC, 65535, 4, ST_OK);
    plan_check(CMD_FREE, 3, 0, ST_OK);
    plan_check(CMD_ALLOC, 0, 3, ST_OK);
    plan_check(CMD_FREE, 0, 0, ST_BELOW);
    plan_check(CMD_FREE, 2, 0, ST_BELOW);
    plan_check(CMD_FREE, 65535, 0, ST_BEYOND);
    plan_check(CMD_FREE, 4099, 0, ST_BEYOND);  // first bit of an unused map block
    plan_check(CMD_FREE, 4098, 0, ST_OK);      // last bit, already free
    plan_reg(REG_USABLE_COUNT, 2);
    plan_check(CMD_ALLOC, 0, 0, ST_FULL);
    plan_reg(REG_USABLE_COUNT, 0);
    plan_check(CMD_ALLOC, 0, 0, ST_FULL);
    // no map blocks: base 2, nothing to scan
    plan_reg(REG_USABLE_COUNT, 32767);
    plan_reg(REG_MAP_BLOCKS, 0);
    plan_check(CMD_ALLOC, 0, 0, ST_FULL);
    plan_check(CMD_FREE, 2, 0, ST_BEYOND);
    plan_check(CMD_FREE, 1, 0, ST_BELOW);
    // map blocks past the store: base 9, scan clipped to the store
    plan_reg(REG_MAP_BLOCKS, 7);
    plan_op(CMD_ALLOC, 0);
    plan_op(CMD_FREE, 9 + MAP_BITS - 1);
    plan_check(CMD_FREE, 9 + MAP_BITS, 0, ST_BEYOND);
    plan_reg(REG_INODE_BLOCKS, 32767);  // upper bits dropped, base 1031
    plan_check(CMD_FREE, 1030, 0, ST_BELOW);
    plan_check(CMD_FREE, 65535, 0, ST_BEYOND);
    plan_reg(REG_SPARE, 32767);
    plan_op(CMD_ALLOC, 23130);
    // bit past usable_count can be freed but never granted
    plan_reg(REG_INODE_BLOCKS, 0);
    plan_reg(REG_MAP_BLOCKS, 32761);
    plan_reg(REG_USABLE_COUNT, 2);
    plan_op(CMD_FREE, 102);
    plan_check(CMD_ALLOC, 0, 0, ST_FULL);
    plan_check(CMD_FREE, 2, 0, ST_OK);
    plan_check(CMD_ALLOC, 0, 2, ST_OK);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < plan.size(); k++) begin
      row = plan[k];
      if (row.is_cfg) begin
        drain();
        write_reg(row.idx, row.data);
      end else begin
        send_item(row.cmd, row.blk, row.fixed, row.want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      ib = $urandom_range(0, 32767);
      case (p)
        0: begin ib = 0; mb = 1; uc = 24; end
        1: begin ib = 32767; mb = 4; uc = 16384; end
        2: begin mb = 2; uc = $urandom_range(1, 40); end
        3: begin mb = 32767; uc = 32767; end
        4: begin mb = 3; uc = $urandom_range(1, 40); end
        5: begin mb = 32765; uc = $urandom_range(0, 200); end
        default: begin mb = $urandom_range(0, 32767); uc = $urandom_range(1, 40); end
      endcase
      drain();
      write_reg(REG_INODE_BLOCKS, CFG_DAT_W'(ib));
      write_reg(REG_MAP_BLOCKS, CFG_DAT_W'(mb));
      write_reg(REG_USABLE_COUNT, CFG_DAT_W'(uc));
      if ($urandom_range(0, 1)) write_reg(REG_SPARE, CFG_DAT_W'($urandom));
      base = data_base();
      lim = scan_limit();
      span = (lim > 48 ? 48 : lim) + 3;
      repeat (PHASE_OPS) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          send_item(CMD_ALLOC, BLK_W'($urandom), 1'b0, none);
        end else begin
          // mostly frees of blocks near the low end that allocation hands out
          if (r < 80) blk = BLK_W'(base + $urandom_range(0, span));
          else if (r < 88) blk = BLK_W'(base + $urandom_range(0, MAP_BITS + 63));
          else if (r < 94) blk = BLK_W'($urandom_range(0, base - 1));
          else blk = BLK_W'($urandom);
          send_item(CMD_FREE, blk, 1'b0, none);
        end
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (n_bad == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : receive_results
    int unsigned hold;
    grant_t w;
    wait (rst_n === 1'b1);
    forever begin
      // one long stall so the block backs up onto its input
      if (n_got == HOLD_AT) hold = HOLD_LEN;
      else if ((n_got % 100) >= 60 && (n_got % 100) < 80) hold = 0;
      else hold = $urandom_range(0, 4);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (grants_due.size() == 0) begin
        $display("%0t: result with nothing pending, granted_block %0d status %0d",
                 $time, out_granted_block, out_status);
        n_bad++;
      end else begin
        w = grants_due.pop_front();
        if (w.blk !== out_granted_block) begin
          $display("%0t: granted_block expected %0d actual %0d",
                   $time, w.blk, out_granted_block);
          n_bad++;
        end
        if (w.st !== out_status) begin
          $display("%0t: status expected %0d actual %0d", $time, w.st, out_status);
          n_bad++;
        end
      end
      n_got++;
    end
  end

  initial begin : watchdog
    #12_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
design/bba_pkg.sv
design/bba_ctrl.sv
design/bba_dpath.sv
design/bitmap_block_allocator.sv
test/tb_bitmap_block_allocator.sv
